/* hw/rtl/fwp_pkg.sv */
// fwp_pkg: shared widths, command codes and types for the fir filter with prime
// no dependencies; compile first
`timescale 1ns / 1ps

package fwp_pkg;

	localparam int CMD_W         = 2;
	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 18;
	localparam int IDX_W         = 5;
	localparam int PROD_W        = SAMPLE_W + COEF_W;
	localparam int FRAC_W        = 15;
	// coefficient index field reaches only this many taps
	localparam int MAX_LOAD_TAPS = 1 << IDX_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_PRIME  = 2'd1,
		CMD_LOAD   = 2'd2
	} cmd_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;

	localparam sample_t SAT_MAX = 16'sh7fff;
	localparam sample_t SAT_MIN = 16'sh8000;

	// decoded command of an accepted input beat
	typedef struct packed {
		logic sample;
		logic prime;
		logic load;
	} cmd_strobe_t;

endpackage

/* hw/rtl/fwp_if.sv */
// fwp_in_if / fwp_out_if: valid-ready channels for filter commands and results
// depends on fwp_pkg
`timescale 1ns / 1ps

interface fwp_in_if;
	logic                     valid;
	logic                     ready;
	logic [fwp_pkg::CMD_W-1:0] command;
	fwp_pkg::sample_t         sample_value;
	logic [fwp_pkg::IDX_W-1:0] coef_index;
	fwp_pkg::coef_t           coef_value;

	modport source (output valid, command, sample_value, coef_index, coef_value,
		input ready);
	modport sink (input valid, command, sample_value, coef_index, coef_value,
		output ready);
endinterface

interface fwp_out_if;
	logic             valid;
	logic             ready;
	fwp_pkg::sample_t filtered_sample;
	logic             saturated;

	modport source (output valid, filtered_sample, saturated, input ready);
	modport sink (input valid, filtered_sample, saturated, output ready);
endinterface

/* hw/rtl/fwp_taps.sv */
// fwp_taps: delay line, coefficient store and one multiplier per tap
// depends on fwp_pkg
`timescale 1ns / 1ps

module fwp_taps #(
	parameter int TAPS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fwp_pkg::cmd_strobe_t      strobe,
	input  fwp_pkg::sample_t          sample_value,
	input  logic [fwp_pkg::IDX_W-1:0] coef_index,
	input  fwp_pkg::coef_t            coef_value,
	output fwp_pkg::prod_t            prod [TAPS]
);

	fwp_pkg::sample_t line_q   [TAPS];
	fwp_pkg::coef_t   weight_q [TAPS];
	fwp_pkg::sample_t tap_x    [TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				line_q[i]   <= '0;
				weight_q[i] <= '0;
			end
		end else begin
			if (strobe.prime) begin
				for (int i = 0; i < TAPS; i++) line_q[i] <= sample_value;
			end else if (strobe.sample) begin
				for (int i = 0; i < TAPS; i++) line_q[i] <= tap_x[i];
			end
			if (strobe.load) begin
				for (int i = 0; i < TAPS; i++) begin
					if (i < fwp_pkg::MAX_LOAD_TAPS && coef_index == fwp_pkg::IDX_W'(i))
						weight_q[i] <= coef_value;
				end
			end
		end
	end

	// line contents after the shift; newest sample at tap 0
	for (genvar i = 0; i < TAPS; i++) begin : g_tap
		if (i == 0) begin : g_head
			assign tap_x[i] = sample_value;
		end else begin : g_body
			assign tap_x[i] = line_q[i-1];
		end
		assign prod[i] = weight_q[i] * tap_x[i];
	end

endmodule

/* hw/rtl/fwp_sum_tree.sv */
// fwp_sum_tree: registered binary adder tree, one level per stage, elastic flow
// depends on fwp_pkg
`timescale 1ns / 1ps

module fwp_sum_tree #(
	parameter int TAPS  = 32,
	parameter int LVLS  = 5,
	parameter int ACC_W = 39
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    leaf_load,
	input  fwp_pkg::prod_t          prod [TAPS],
	input  logic                    take,
	output logic                    up_ready,
	output logic                    root_valid,
	output logic signed [ACC_W-1:0] root_sum
);

	localparam int NP = 1 << LVLS;

	// heap order: node k adds nodes 2k and 2k+1, leaves at NP..2NP-1
	logic signed [ACC_W-1:0] node_q [1:2*NP-1];
	logic [LVLS:0]           v_q;
	logic [LVLS:0]           mv;

	// stage d moves its beat on when the stage below is empty or moving too
	always_comb begin
		mv[0] = v_q[0] && take;
		for (int d = 1; d <= LVLS; d++) mv[d] = v_q[d] && (!v_q[d-1] || mv[d-1]);
	end

	assign up_ready   = !v_q[LVLS] || mv[LVLS];
	assign root_valid = v_q[0];
	assign root_sum   = node_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int d = 0; d <= LVLS; d++) begin
				if (d == LVLS ? leaf_load : mv[(d + 1) % (LVLS + 1)]) v_q[d] <= 1'b1;
				else if (mv[d]) v_q[d] <= 1'b0;
			end
		end
	end

	for (genvar j = 0; j < NP; j++) begin : g_leaf
		if (j < TAPS) begin : g_used
			always_ff @(posedge clk) begin
				if (leaf_load) node_q[NP+j] <= ACC_W'(prod[j]);
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				if (leaf_load) node_q[NP+j] <= '0;
			end
		end
	end

	for (genvar k = 1; k < NP; k++) begin : g_node
		localparam int D = $clog2(k + 1) - 1;
		always_ff @(posedge clk) begin
			if (mv[D+1]) node_q[k] <= node_q[2*k] + node_q[2*k+1];
		end
	end

endmodule

/* hw/rtl/fwp_round_sat.sv */
// fwp_round_sat: floor shift, saturation and the result register
// depends on fwp_pkg and fwp_if
`timescale 1ns / 1ps

module fwp_round_sat #(
	parameter int ACC_W = 39
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    root_valid,
	input  logic signed [ACC_W-1:0] root_sum,
	output logic                    take,
	fwp_out_if.source               result
);

	logic                    valid_q;
	fwp_pkg::sample_t        sample_q;
	logic                    sat_q;
	logic signed [ACC_W-1:0] shifted;
	logic                    over;
	logic                    under;

	assign take    = !valid_q || result.ready;
	assign shifted = root_sum >>> fwp_pkg::FRAC_W;
	assign over    = shifted > ACC_W'(fwp_pkg::SAT_MAX);
	assign under   = shifted < ACC_W'(fwp_pkg::SAT_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= root_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && root_valid) begin
			priority if (over) sample_q <= fwp_pkg::SAT_MAX;
			else if (under) sample_q <= fwp_pkg::SAT_MIN;
			else sample_q <= shifted[fwp_pkg::SAMPLE_W-1:0];
			sat_q <= over || under;
		end
	end

	assign result.valid           = valid_q;
	assign result.filtered_sample = sample_q;
	assign result.saturated       = sat_q;

endmodule

/* hw/rtl/fir_filter_with_prime.sv */
// pipeline: multiply into the leaf registers on the accepting edge, then one adder-tree
// level per stage, then shift/saturate; one beat per cycle unless a held result backs up
// every stage, and command beats are taken alongside the pipeline
// reset (arst_n low): delay line and coefficients clear to zero, pipeline empties
// depends on fwp_pkg, fwp_if, fwp_taps, fwp_sum_tree, fwp_round_sat
`timescale 1ns / 1ps

module fir_filter_with_prime #(
	parameter int TAPS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	fwp_in_if.sink    item,
	fwp_out_if.source result
);

	// tree depth and the exact width of the full sum
	localparam int LVLS  = $clog2(TAPS);
	localparam int ACC_W = fwp_pkg::PROD_W + LVLS;

	fwp_pkg::cmd_strobe_t    strobe;
	fwp_pkg::prod_t          prod [TAPS];
	logic                    up_ready;
	logic                    take;
	logic                    root_valid;
	logic signed [ACC_W-1:0] root_sum;
	logic                    accept;

	// the tree takes a new beat whenever its first stage is free or draining,
	// so a waiting result does not stop input until every stage is full
	assign item.ready = up_ready;
	assign accept     = item.valid && item.ready;

	// command decode; the unused code yields no strobe and is dropped
	always_comb begin
		strobe.sample = accept && item.command == fwp_pkg::CMD_SAMPLE;
		strobe.prime  = accept && item.command == fwp_pkg::CMD_PRIME;
		strobe.load   = accept && item.command == fwp_pkg::CMD_LOAD;
	end

	// state updates and all tap products happen on the accepting edge, so later
	// prime or load beats cannot disturb a sample already in the tree
	fwp_taps #(
		.TAPS (TAPS)
	) u_taps (
		.clk          (clk),
		.arst_n       (arst_n),
		.strobe       (strobe),
		.sample_value (item.sample_value),
		.coef_index   (item.coef_index),
		.coef_value   (item.coef_value),
		.prod         (prod)
	);

	// products land in the leaf registers, then pass one registered add level per stage
	fwp_sum_tree #(
		.TAPS  (TAPS),
		.LVLS  (LVLS),
		.ACC_W (ACC_W)
	) u_tree (
		.clk        (clk),
		.arst_n     (arst_n),
		.leaf_load  (strobe.sample),
		.prod       (prod),
		.take       (take),
		.up_ready   (up_ready),
		.root_valid (root_valid),
		.root_sum   (root_sum)
	);

	// floor shift by 15, clip to 16-bit signed, hold until the sink takes it
	fwp_round_sat #(
		.ACC_W (ACC_W)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.root_valid (root_valid),
		.root_sum   (root_sum),
		.take       (take),
		.result     (result)
	);

endmodule

/* hw/rtl/fwp_checker.sv */
// fwp_checker: port-level assertions for fir_filter_with_prime, bound to the top
// depends on fwp_pkg
`timescale 1ns / 1ps

module fwp_checker #(
	parameter int TAPS = 32
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_ready,
	input logic [fwp_pkg::CMD_W-1:0] item_command,
	input logic                      result_valid,
	input logic                      result_ready,
	input fwp_pkg::sample_t          result_filtered_sample,
	input logic                      result_saturated
);

	localparam int DEPTH = $clog2(TAPS) + 2;
	localparam int CNT_W = $clog2(DEPTH + 1) + 1;

	logic [CNT_W-1:0] cnt_q;
	logic             in_s;
	logic             out_s;

	assign in_s  = item_valid && item_ready && item_command == fwp_pkg::CMD_SAMPLE;
	assign out_s = result_valid && result_ready;

	// sample beats accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_s && !out_s) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (!in_s && out_s) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
			&& $stable(result_filtered_sample) && $stable(result_saturated))
		else $error("result beat changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("input stalled without a stalled result");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_saturated |-> result_filtered_sample == fwp_pkg::SAT_MAX
			|| result_filtered_sample == fwp_pkg::SAT_MIN)
		else $error("saturated flag with an unclipped value");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cnt_q != '0)
		else $error("result without a pending sample");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("more samples in flight than pipeline stages");

endmodule

bind fir_filter_with_prime fwp_checker #(
	.TAPS (TAPS)
) u_fwp_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.item_valid             (item.valid),
	.item_ready             (item.ready),
	.item_command           (item.command),
	.result_valid           (result.valid),
	.result_ready           (result.ready),
	.result_filtered_sample (result.filtered_sample),
	.result_saturated       (result.saturated)
);

/* tb/tb_fir_filter_with_prime.sv */
// tb_fir_filter_with_prime: self-checking bench for the 32-tap fir filter with prime
// depends on fwp_pkg, fwp_if and the fir_filter_with_prime rtl
`timescale 1ns / 1ps

module tb_fir_filter_with_prime;

	localparam int N_TAPS = 32;
	// settle unit for the final wait before the verdict
	localparam int LATENCY = 6;
	localparam int unsigned CYCLE_LIMIT = 200000;
	// the one code the command field can carry that the block ignores
	localparam logic [fwp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 470;
	localparam int RX_HOLD_CYCLES = 300;

	typedef struct packed {
		fwp_pkg::sample_t value;
		logic             sat;
	} filt_res_t;

	// predicts every filtered sample and checks the outputs against it in order
	class filtered_sample_board;
		fwp_pkg::sample_t hist[N_TAPS];
		fwp_pkg::coef_t   weights[N_TAPS];
		filt_res_t        expected[$];
		int               fault_count;

		function new();
			foreach (hist[i]) begin
				hist[i] = '0;
				weights[i] = '0;
			end
			fault_count = 0;
		endfunction

		function void apply_command(logic [fwp_pkg::CMD_W-1:0] cmd, fwp_pkg::sample_t smp,
				logic [fwp_pkg::IDX_W-1:0] idx, fwp_pkg::coef_t wt);
			longint    acc;
			longint    quo;
			filt_res_t res;
			unique case (cmd)
				fwp_pkg::CMD_SAMPLE: begin
					for (int i = N_TAPS - 1; i > 0; i--)
						hist[i] = hist[i-1];
					hist[0] = smp;
					acc = 0;
					for (int i = 0; i < N_TAPS; i++)
						acc += longint'(weights[i]) * longint'(hist[i]);
					// arithmetic shift gives the floor, clip after the shift
					quo = acc >>> fwp_pkg::FRAC_W;
					res.sat = 1'b1;
					if (quo > longint'(fwp_pkg::SAT_MAX)) begin
						res.value = fwp_pkg::SAT_MAX;
					end else if (quo < longint'(fwp_pkg::SAT_MIN)) begin
						res.value = fwp_pkg::SAT_MIN;
					end else begin
						res.value = fwp_pkg::sample_t'(quo);
						res.sat = 1'b0;
					end
					expected.push_back(res);
				end
				fwp_pkg::CMD_PRIME: begin
					foreach (hist[i])
						hist[i] = smp;
				end
				fwp_pkg::CMD_LOAD: begin
					if (int'(idx) < N_TAPS)
						weights[idx] = wt;
				end
				default: begin
				end
			endcase
		endfunction

		function void check_filtered(fwp_pkg::sample_t got, logic got_sat);
			filt_res_t want;
			if (expected.size() == 0) begin
				$display("%0t: unexpected result filtered_sample %0d saturated %0b",
					$time, got, got_sat);
				fault_count++;
				return;
			end
			want = expected.pop_front();
			if (got !== want.value) begin
				$display("%0t: filtered_sample expected %0d actual %0d",
					$time, want.value, got);
				fault_count++;
			end
			if (got_sat !== want.sat) begin
				$display("%0t: saturated expected %0b actual %0b",
					$time, want.sat, got_sat);
				fault_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fwp_in_if  cmd_ch();
	fwp_out_if res_ch();

	filtered_sample_board board = new();

	// idle percentages for each side, changed per phase by the main sequence
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	// count of long receiver hold-offs asked for by the main sequence
	int unsigned rx_hold_reqs;
	int unsigned cycle_count;

	fir_filter_with_prime #(
		.TAPS(N_TAPS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd_ch),
		.result (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit: far above the slowest legal run, even with both sides idling hard
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// result side: check every accepted beat, then pick ready for the next edge
	initial begin
		int unsigned hold_left;
		int unsigned holds_taken;
		hold_left = 0;
		holds_taken = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				board.check_filtered(res_ch.filtered_sample, res_ch.saturated);
			if (rx_hold_reqs != holds_taken) begin
				// long stall so the pipeline fills and backs up into the input
				hold_left = RX_HOLD_CYCLES;
				holds_taken = rx_hold_reqs;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// offer one command beat, with random idle cycles ahead of it, and wait for acceptance
	task automatic send_beat(input logic [fwp_pkg::CMD_W-1:0] cmd,
			input fwp_pkg::sample_t smp, input logic [fwp_pkg::IDX_W-1:0] idx,
			input fwp_pkg::coef_t wt);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= cmd;
		cmd_ch.sample_value <= smp;
		cmd_ch.coef_index   <= idx;
		cmd_ch.coef_value   <= wt;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		board.apply_command(cmd, smp, idx, wt);
	endtask

	// sender stops offering until every predicted sample has come back
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (board.expected.size() != 0);
	endtask

	// mostly small weights so that many sums stay in range, some extremes for clipping
	function automatic fwp_pkg::coef_t pick_weight();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 78)
			return fwp_pkg::coef_t'(int'($urandom_range(1023)) - 512);
		else if (r < 88)
			return '0;
		else if (r < 94)
			return fwp_pkg::coef_t'($urandom);
		else if (r < 97)
			return fwp_pkg::coef_t'(18'sh1ffff);
		else
			return fwp_pkg::coef_t'(18'sh20000);
	endfunction

	function automatic fwp_pkg::sample_t pick_sample();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return fwp_pkg::SAT_MAX;
		else if (r < 10)
			return fwp_pkg::SAT_MIN;
		else if (r < 55)
			return fwp_pkg::sample_t'($urandom);
		else
			return fwp_pkg::sample_t'(int'($urandom_range(2047)) - 1024);
	endfunction

	// one random beat; counted is low for the ignored command code
	task automatic send_random(output bit counted);
		int unsigned               r;
		logic [fwp_pkg::CMD_W-1:0] cmd;
		r = $urandom_range(99);
		if (r < 62)
			cmd = fwp_pkg::CMD_SAMPLE;
		else if (r < 68)
			cmd = fwp_pkg::CMD_PRIME;
		else if (r < 94)
			cmd = fwp_pkg::CMD_LOAD;
		else
			cmd = CMD_UNUSED;
		counted = (cmd != CMD_UNUSED);
		send_beat(cmd, pick_sample(), fwp_pkg::IDX_W'($urandom), pick_weight());
	endtask

	task automatic run_random(input int count, input bit hold_first, input bit mid_pause);
		int  n;
		bit  counted;
		n = 0;
		if (hold_first)
			rx_hold_reqs++;
		while (n < count) begin
			send_random(counted);
			if (counted)
				n++;
			if (mid_pause && n == count / 2 && counted)
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		rx_hold_reqs = 0;
		tx_idle_pct = 36;
		rx_idle_pct = 65;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.command      <= fwp_pkg::CMD_SAMPLE;
		cmd_ch.sample_value <= '0;
		cmd_ch.coef_index   <= '0;
		cmd_ch.coef_value   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all weights still zero, so a full-scale sample gives zero
		send_beat(fwp_pkg::CMD_SAMPLE, fwp_pkg::SAT_MAX, '0, '0);
		// largest and smallest weight at the two ends of the line
		send_beat(fwp_pkg::CMD_LOAD, fwp_pkg::sample_t'($urandom), 5'd0, 18'sh1ffff);
		send_beat(fwp_pkg::CMD_LOAD, fwp_pkg::sample_t'($urandom), 5'd31, 18'sh20000);
		// full line of max samples: the two ends nearly cancel, floor gives -1
		send_beat(fwp_pkg::CMD_PRIME, fwp_pkg::SAT_MAX, fwp_pkg::IDX_W'($urandom),
			fwp_pkg::coef_t'($urandom));
		send_beat(fwp_pkg::CMD_SAMPLE, fwp_pkg::SAT_MAX, fwp_pkg::IDX_W'($urandom),
			fwp_pkg::coef_t'($urandom));
		send_beat(fwp_pkg::CMD_LOAD, '0, 5'd31, '0);
		// weight near 4.0 on full scale: clips high
		send_beat(fwp_pkg::CMD_SAMPLE, fwp_pkg::SAT_MAX, '0, '0);
		// and clips low after priming with the most negative value
		send_beat(fwp_pkg::CMD_PRIME, fwp_pkg::SAT_MIN, '0, '0);
		send_beat(fwp_pkg::CMD_SAMPLE, fwp_pkg::SAT_MIN, '0, '0);
		// unused command code with every field at an extreme: no effect at all
		send_beat(CMD_UNUSED, fwp_pkg::SAT_MAX, 5'd31, 18'sh1ffff);
		send_beat(CMD_UNUSED, fwp_pkg::SAT_MIN, 5'd0, 18'sh20000);
		// smallest positive weight on a tiny negative sample: floor rounds away from zero
		send_beat(fwp_pkg::CMD_LOAD, fwp_pkg::SAT_MIN, 5'd0, 18'sd1);
		send_beat(fwp_pkg::CMD_PRIME, '0, 5'd31, 18'sh1ffff);
		send_beat(fwp_pkg::CMD_SAMPLE, -16'sd1, '0, '0);
		send_beat(fwp_pkg::CMD_SAMPLE, 16'sd1, '0, '0);
		send_beat(fwp_pkg::CMD_LOAD, '0, 5'd1, 18'sh20000);
		send_beat(fwp_pkg::CMD_SAMPLE, fwp_pkg::SAT_MIN, '0, '0);
		// unity weight on the oldest tap, walked through by fresh samples
		send_beat(fwp_pkg::CMD_LOAD, '0, 5'd31, 18'sd32768);
		send_beat(fwp_pkg::CMD_PRIME, 16'sd100, '0, '0);
		send_beat(fwp_pkg::CMD_SAMPLE, 16'sd7, '0, '0);
		send_beat(fwp_pkg::CMD_LOAD, fwp_pkg::SAT_MAX, 5'd31, 18'sh1ffff);
		send_beat(fwp_pkg::CMD_SAMPLE, 16'sh5555, '0, '0);
		send_beat(fwp_pkg::CMD_SAMPLE, -16'sh5556, '0, '0);
		drain_results();

		// sender idles lightly, receiver heavily; opens with a long receiver stall
		run_random(ITEMS_PER_PHASE, 1'b1, 1'b0);

		// the other way round, with a full drain halfway
		tx_idle_pct = 65;
		rx_idle_pct = 36;
		run_random(ITEMS_PER_PHASE, 1'b0, 1'b1);

		// back to back on both sides, again with a long stall at the start
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(ITEMS_PER_PHASE, 1'b1, 1'b0);

		// let any stray beat show up before the verdict
		repeat (3 * LATENCY) @(posedge clk);
		if (board.fault_count == 0 && board.expected.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/fwp_pkg.sv
hw/rtl/fwp_if.sv
hw/rtl/fwp_taps.sv
hw/rtl/fwp_sum_tree.sv
hw/rtl/fwp_round_sat.sv
hw/rtl/fir_filter_with_prime.sv
hw/rtl/fwp_checker.sv
tb/tb_fir_filter_with_prime.sv
